// ===== hdl/msfd_pkg.sv =====
// ----------------------------------------------------------------------------
// msfd_pkg
// Shared widths, register indexes and reset values of the median-smoothed
// fire detector.
// ----------------------------------------------------------------------------
package msfd_pkg;

  localparam int DATA_W     = 16;
  localparam int RISE_W     = 5;
  localparam int CFG_IDX_W  = 2;

  // default window lengths
  localparam int MEDIAN_LEN_DEF = 5;
  localparam int SMOOTH_LEN_DEF = 30;

  // high flags are counted in groups of this many before the final sum
  localparam int GRP_LEN = 8;
  localparam int PART_W  = 4;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LEVEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPIKE_DELTA = 2'd2;

  localparam logic signed [DATA_W-1:0] HIGH_LEVEL_RST  = 16'sd58;
  localparam logic [RISE_W-1:0]        RISE_COUNT_RST  = 5'd27;
  localparam logic [DATA_W-1:0]        SPIKE_DELTA_RST = 16'd8;

endpackage

// ===== hdl/msfd_cell.sv =====
// ----------------------------------------------------------------------------
// msfd_cell
// One window cell: holds a sample, hands it to its neighbour on a shift and
// flags whether the held value is at or above a level.
// ----------------------------------------------------------------------------
module msfd_cell #(
  parameter int W = msfd_pkg::DATA_W
) (
  input  logic                clk,
  input  logic                shift,
  input  logic signed [W-1:0] d,
  input  logic signed [W-1:0] level,
  output logic signed [W-1:0] q,
  output logic                high
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

  assign high = (q >= level);

endmodule

// ===== hdl/msfd_median.sv =====
// ----------------------------------------------------------------------------
// msfd_median
// Median of a small window by rank counting: each entry counts the entries
// that sort before it, the one with the middle rank is the median.
// ----------------------------------------------------------------------------
module msfd_median #(
  parameter int N = msfd_pkg::MEDIAN_LEN_DEF,
  parameter int W = msfd_pkg::DATA_W
) (
  input  logic signed [W-1:0] win [N],
  output logic signed [W-1:0] med
);

  localparam int RANK_W = $clog2(N);
  localparam int MID    = (N - 1) / 2;

  logic [RANK_W-1:0] rank [N];

  always_comb begin
    med = '0;
    for (int i = 0; i < N; i++) begin
      rank[i] = '0;
      for (int j = 0; j < N; j++) begin
        // ties broken by position so ranks form a permutation
        if (j != i && (win[j] < win[i] || (win[j] == win[i] && j < i))) begin
          rank[i] = rank[i] + RANK_W'(1);
        end
      end
      if (rank[i] == RANK_W'(MID)) begin
        med = win[i];
      end
    end
  end

endmodule

// ===== hdl/median_smoothed_fire_detector.sv =====
// ----------------------------------------------------------------------------
// median_smoothed_fire_detector
// Median filter over raw samples feeding a window of smoothed values, with
// level-count and rate-of-rise alarms and a sticky alarm.
// ----------------------------------------------------------------------------
// One item is taken per clock while the pipeline does not stall, and each
// item gives one result. Both windows are rows of shift cells that move
// one place per item; a four-stage pipeline (raw shift, median and smoothed
// shift, grouped high count and difference, final sum and compare) stalls as
// a whole only while a finished result waits on out_ready, so in_ready
// follows out_ready whenever the output register is full. Configuration
// writes are always taken.
module median_smoothed_fire_detector #(
  parameter int MEDIAN_LEN = msfd_pkg::MEDIAN_LEN_DEF,
  parameter int SMOOTH_LEN = msfd_pkg::SMOOTH_LEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [msfd_pkg::DATA_W-1:0]  temp,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [msfd_pkg::DATA_W-1:0]  median_value,
  output logic                                median_valid,
  output logic                                rise_alarm,
  output logic                                spike_alarm,
  output logic                                alarm_latched,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [msfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [msfd_pkg::DATA_W-1:0]         cfg_data
);

  localparam int W          = msfd_pkg::DATA_W;
  localparam int RAW_FILL_W = $clog2(MEDIAN_LEN + 1);
  localparam int SM_FILL_W  = $clog2(SMOOTH_LEN + 1);
  localparam int CNT_W      = $clog2(SMOOTH_LEN + 1);
  localparam int CMP_W      = (CNT_W > msfd_pkg::RISE_W) ? CNT_W : msfd_pkg::RISE_W;
  localparam int NGRP       = (SMOOTH_LEN + msfd_pkg::GRP_LEN - 1) / msfd_pkg::GRP_LEN;
  localparam int PAD_LEN    = NGRP * msfd_pkg::GRP_LEN;

  // configuration
  logic signed [W-1:0]              high_level;
  logic [msfd_pkg::RISE_W-1:0]      rise_count;
  logic [W-1:0]                     spike_delta;

  // pipeline control
  logic                     advance;
  logic                     va, vb, vc;
  logic [RAW_FILL_W-1:0]    raw_fill;
  logic [SM_FILL_W-1:0]     smooth_fill;
  logic                     raw_full;
  logic                     raw_shift;
  logic                     smooth_shift;
  logic                     alarm_flag;

  // cell rows
  logic signed [W-1:0]      raw_q [MEDIAN_LEN];
  logic signed [W-1:0]      smooth_q [SMOOTH_LEN];
  logic [SMOOTH_LEN-1:0]    smooth_high;
  logic signed [W-1:0]      med;

  // stage registers
  logic                     mvalid_b;
  logic signed [W-1:0]      median_b;
  logic                     mvalid_c;
  logic signed [W-1:0]      median_c;
  logic                     full_c;
  logic [W:0]               diff_c;
  logic [msfd_pkg::PART_W-1:0] part_c [NGRP];

  // final stage logic
  logic [PAD_LEN-1:0]       high_pad;
  logic [CNT_W-1:0]         high_cnt;
  logic                     rise;
  logic                     spike;
  logic                     alarm_flag_next;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;

  assign raw_full     = (raw_fill == RAW_FILL_W'(MEDIAN_LEN));
  assign raw_shift    = in_valid && advance;
  assign smooth_shift = advance && va && raw_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_level  <= msfd_pkg::HIGH_LEVEL_RST;
      rise_count  <= msfd_pkg::RISE_COUNT_RST;
      spike_delta <= msfd_pkg::SPIKE_DELTA_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        msfd_pkg::REG_HIGH_LEVEL:  high_level  <= cfg_data;
        msfd_pkg::REG_RISE_COUNT:  rise_count  <= cfg_data[msfd_pkg::RISE_W-1:0];
        msfd_pkg::REG_SPIKE_DELTA: spike_delta <= cfg_data;
        default: ;
      endcase
    end
  end

  // raw sample row, newest at the top end
  for (genvar i = 0; i < MEDIAN_LEN; i++) begin : g_raw
    if (i == MEDIAN_LEN - 1) begin : g_top
      msfd_cell #(.W(W)) u_cell (
        .clk(clk), .shift(raw_shift), .d(temp), .level(high_level),
        .q(raw_q[i]), .high()
      );
    end else begin : g_mid
      msfd_cell #(.W(W)) u_cell (
        .clk(clk), .shift(raw_shift), .d(raw_q[i+1]), .level(high_level),
        .q(raw_q[i]), .high()
      );
    end
  end

  msfd_median #(.N(MEDIAN_LEN), .W(W)) u_median (
    .win(raw_q),
    .med(med)
  );

  // smoothed row, fed by the median
  for (genvar i = 0; i < SMOOTH_LEN; i++) begin : g_smooth
    if (i == SMOOTH_LEN - 1) begin : g_top
      msfd_cell #(.W(W)) u_cell (
        .clk(clk), .shift(smooth_shift), .d(med), .level(high_level),
        .q(smooth_q[i]), .high(smooth_high[i])
      );
    end else begin : g_mid
      msfd_cell #(.W(W)) u_cell (
        .clk(clk), .shift(smooth_shift), .d(smooth_q[i+1]), .level(high_level),
        .q(smooth_q[i]), .high(smooth_high[i])
      );
    end
  end

  assign high_pad = PAD_LEN'(smooth_high);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      va          <= 1'b0;
      vb          <= 1'b0;
      vc          <= 1'b0;
      out_valid   <= 1'b0;
      raw_fill    <= '0;
      smooth_fill <= '0;
      alarm_flag  <= 1'b0;
    end else if (advance) begin
      va        <= in_valid;
      vb        <= va;
      vc        <= vb;
      out_valid <= vc;
      if (raw_shift && !raw_full) begin
        raw_fill <= raw_fill + RAW_FILL_W'(1);
      end
      if (smooth_shift && smooth_fill != SM_FILL_W'(SMOOTH_LEN)) begin
        smooth_fill <= smooth_fill + SM_FILL_W'(1);
      end
      if (vc) begin
        alarm_flag <= alarm_flag_next;
      end
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (advance) begin
      mvalid_b <= raw_full;
      median_b <= raw_full ? med : '0;

      mvalid_c <= mvalid_b;
      median_c <= median_b;
      full_c   <= mvalid_b && (smooth_fill == SM_FILL_W'(SMOOTH_LEN));
      diff_c   <= {smooth_q[SMOOTH_LEN-1][W-1], smooth_q[SMOOTH_LEN-1]}
                - {smooth_q[0][W-1], smooth_q[0]};
      for (int g = 0; g < NGRP; g++) begin
        part_c[g] <= msfd_pkg::PART_W'($countones(
                       high_pad[g*msfd_pkg::GRP_LEN +: msfd_pkg::GRP_LEN]));
      end

      median_value  <= median_c;
      median_valid  <= mvalid_c;
      rise_alarm    <= rise;
      spike_alarm   <= spike;
      alarm_latched <= alarm_flag_next;
    end
  end

  always_comb begin
    high_cnt = '0;
    for (int g = 0; g < NGRP; g++) begin
      high_cnt = high_cnt + CNT_W'(part_c[g]);
    end
  end

  // a negative difference never raises the spike alarm
  assign rise  = full_c && (CMP_W'(high_cnt) >= CMP_W'(rise_count));
  assign spike = full_c && !diff_c[W] && (diff_c[W-1:0] >= spike_delta);
  assign alarm_flag_next = alarm_flag || rise || spike;

  a_latch_sticky: assert property (@(posedge clk) disable iff (rst)
    alarm_flag |=> alarm_flag)
    else $error("sticky alarm dropped without reset");

  a_alarm_latched: assert property (@(posedge clk) disable iff (rst)
    out_valid && (rise_alarm || spike_alarm) |-> alarm_latched)
    else $error("alarm result without latched alarm");

  a_alarm_needs_median: assert property (@(posedge clk) disable iff (rst)
    out_valid && (rise_alarm || spike_alarm) |-> median_valid)
    else $error("alarm raised before median valid");

  a_smooth_after_raw: assert property (@(posedge clk) disable iff (rst)
    smooth_fill != '0 |-> raw_full)
    else $error("smoothed window filled before raw window");

  a_fill_bounds: assert property (@(posedge clk) disable iff (rst)
    raw_fill <= RAW_FILL_W'(MEDIAN_LEN) && smooth_fill <= SM_FILL_W'(SMOOTH_LEN))
    else $error("fill count out of range");

endmodule
